[src/size_class_free_list_pool_defines.svh]
// ----------------------------------------------------------------------------
// Size-class free-list pool: assertion macros
// Shared property forms for the pool's checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_POOL_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_POOL_DEFINES_SVH

// same-cycle implication
`define SCFL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/scfl_pkg.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool: shared package
// Defaults, register map, status codes and the size classification word.
// ----------------------------------------------------------------------------
package scfl_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int LIST_DEPTH_DEF  = 64;
    localparam int HANDLE_BITS_DEF = 32;

    localparam logic [4:0]  MIN_CLASS_RST = 5'd6;
    localparam logic [4:0]  MAX_CLASS_RST = 5'd16;
    localparam logic [31:0] BUDGET_RST    = 32'(1024 * 1024);

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MIN_CLASS = 2'd0,
        REG_MAX_CLASS = 2'd1,
        REG_BUDGET    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_POOLED       = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_UNMANAGED    = 3'd2,
        ST_ZERO         = 3'd3,
        ST_STORED       = 3'd4,
        ST_DROP_UNMAN   = 3'd5,
        ST_DROP_BUDGET  = 3'd6,
        ST_DROP_FULL    = 3'd7
    } status_t;

    typedef struct packed {
        logic        zero;
        logic        pow2;
        logic        managed;
        logic [5:0]  class_off;
        logic [3:0]  class_index;
        logic [31:0] granted_len;
    } class_info_t;

endpackage

[src/scfl_classify.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool: size classifier
// Rounds a size up to a power of two and maps it onto a managed class.
// ----------------------------------------------------------------------------
module scfl_classify #(
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF
) (
    input  logic [31:0]          size_bytes,
    input  logic [4:0]           min_class,
    input  logic [4:0]           max_class,
    output scfl_pkg::class_info_t info
);

    logic [31:0] size_m1;
    logic [5:0]  k;
    logic [5:0]  off;
    logic        zero;
    logic        managed;

    assign size_m1 = size_bytes - 32'd1;
    assign zero    = (size_bytes == 32'd0);

    always_comb
    begin
        k = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (size_m1[i])
            begin
                k = 6'(i + 1);
            end
        end
    end

    assign off     = k - {1'b0, min_class};
    assign managed = !zero && (k >= {1'b0, min_class}) && (k <= {1'b0, max_class})
                     && (off < 6'(NUM_CLASSES));

    always_comb
    begin
        info.zero        = zero;
        info.pow2        = !zero && ((size_bytes & size_m1) == 32'd0);
        info.managed     = managed;
        info.class_off   = off;
        info.class_index = managed ? off[3:0] : 4'd0;
        info.granted_len = (k == 6'd32) ? 32'd0 : (32'd1 << k[4:0]);
    end

endmodule

[src/scfl_class_tab.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool: class table
// Head, tail and count per class in a synchronous memory; valid bits give
// zero for a class never written since reset.
// ----------------------------------------------------------------------------
module scfl_class_tab #(
    parameter int CLS_W = 4,
    parameter int ENT_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [CLS_W-1:0] rd_idx,
    output logic [ENT_W-1:0] rd_entry,
    input  logic             wr_en,
    input  logic [CLS_W-1:0] wr_idx,
    input  logic [ENT_W-1:0] wr_entry
);

    localparam int DEPTH = 2 ** CLS_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

[src/scfl_handle_ram.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool: handle store
// One synchronous memory holding every class FIFO, one read and one write port.
// ----------------------------------------------------------------------------
module scfl_handle_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2 ** ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/size_class_free_list_pool.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool
// A command runs as accept then update: in the cycle start is taken the size is
// classified and the class table is read; in the next cycle (busy high) the
// class entry and the pooled-byte count are updated and written back, and the
// handle store is read or written. The word appears on the result ports with
// done high in the cycle after that, and a new start may be taken in that
// same cycle. The class-table read-modify-write sets this split.
// The receiver cannot stall, so each result must be taken while done is high.
// No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "size_class_free_list_pool_defines.svh"

module size_class_free_list_pool #(
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF,
    parameter int LIST_DEPTH  = scfl_pkg::LIST_DEPTH_DEF,
    parameter int HANDLE_BITS = scfl_pkg::HANDLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [31:0]                 size_bytes,
    input  logic [31:0]                 block_handle,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [31:0]                 handle_out,
    output logic [31:0]                 granted_len,
    output logic [3:0]                  class_index,
    output logic [32:0]                 pooled_bytes,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scfl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ENT_W  = 2 * PTR_W + CNT_W;
    localparam int HADR_W = CLS_W + PTR_W;
    localparam int HW     = (HANDLE_BITS > 32) ? HANDLE_BITS : 32;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  min_class_reg;
    logic [4:0]  max_class_reg;
    logic [31:0] budget_reg;
    logic [32:0] held_reg, held_next;
    logic        done_reg;

    logic                  cmd_reg;
    logic [31:0]           handle_reg;
    scfl_pkg::class_info_t info_reg;
    scfl_pkg::status_t     status_reg, status_next;
    logic [31:0]           granted_reg;
    logic [3:0]            class_idx_reg;
    logic                  pop_flag_reg;

    scfl_pkg::class_info_t info;
    logic                  accept;
    logic                  exec;
    logic                  cfg_wr;
    logic [CLS_W-1:0]      cls;

    logic [ENT_W-1:0] tab_rd;
    logic [ENT_W-1:0] tab_wr;
    logic [PTR_W-1:0] head, tail, head_inc, tail_inc;
    logic [CNT_W-1:0] cnt, cnt_new;
    logic             pop, push;

    logic [HW-1:0]          handle_ext;
    logic [HANDLE_BITS-1:0] ram_rdata;
    logic [HW-1:0]          ram_rdata_ext;

    assign accept = start && !busy;
    assign busy   = (state_reg == S_EXEC);
    assign exec   = (state_reg == S_EXEC);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    scfl_classify #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_classify (
        .size_bytes (size_bytes),
        .min_class  (min_class_reg),
        .max_class  (max_class_reg),
        .info       (info)
    );

    scfl_class_tab #(
        .CLS_W (CLS_W),
        .ENT_W (ENT_W)
    ) u_class_tab (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_idx   (info.class_off[CLS_W-1:0]),
        .rd_entry (tab_rd),
        .wr_en    (pop || push),
        .wr_idx   (cls),
        .wr_entry (tab_wr)
    );

    assign cls = info_reg.class_off[CLS_W-1:0];
    assign {head, tail, cnt} = tab_rd;
    assign head_inc = (head == PTR_W'(LIST_DEPTH - 1)) ? '0 : head + 1'b1;
    assign tail_inc = (tail == PTR_W'(LIST_DEPTH - 1)) ? '0 : tail + 1'b1;
    assign cnt_new  = pop ? cnt - 1'b1 : cnt + 1'b1;
    assign tab_wr   = {pop ? head_inc : head, push ? tail_inc : tail, cnt_new};

    assign handle_ext = HW'(handle_reg);

    scfl_handle_ram #(
        .ADDR_W (HADR_W),
        .DATA_W (HANDLE_BITS)
    ) u_handle_ram (
        .clk   (clk),
        .we    (push),
        .waddr ({cls, tail}),
        .wdata (handle_ext[HANDLE_BITS-1:0]),
        .re    (pop),
        .raddr ({cls, head}),
        .rdata (ram_rdata)
    );

    assign ram_rdata_ext = HW'(ram_rdata);

    always_comb
    begin
        status_next = scfl_pkg::ST_ZERO;
        held_next   = held_reg;
        pop         = 1'b0;
        push        = 1'b0;
        if (exec)
        begin
            if (!cmd_reg)
            begin
                if (info_reg.zero)
                begin
                    status_next = scfl_pkg::ST_ZERO;
                end
                else if (!info_reg.managed)
                begin
                    status_next = scfl_pkg::ST_UNMANAGED;
                end
                else if (cnt == '0)
                begin
                    status_next = scfl_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = scfl_pkg::ST_POOLED;
                    pop         = 1'b1;
                    held_next   = (held_reg >= {1'b0, info_reg.granted_len})
                                  ? held_reg - {1'b0, info_reg.granted_len} : 33'd0;
                end
            end
            else
            begin
                if (!info_reg.pow2 || !info_reg.managed)
                begin
                    status_next = scfl_pkg::ST_DROP_UNMAN;
                end
                else if (held_reg >= {1'b0, budget_reg})
                begin
                    status_next = scfl_pkg::ST_DROP_BUDGET;
                end
                else if (cnt >= CNT_W'(LIST_DEPTH))
                begin
                    status_next = scfl_pkg::ST_DROP_FULL;
                end
                else
                begin
                    status_next = scfl_pkg::ST_STORED;
                    push        = 1'b1;
                    held_next   = held_reg + {1'b0, info_reg.granted_len};
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            held_reg      <= '0;
            min_class_reg <= scfl_pkg::MIN_CLASS_RST;
            max_class_reg <= scfl_pkg::MAX_CLASS_RST;
            budget_reg    <= scfl_pkg::BUDGET_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            held_reg  <= held_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    scfl_pkg::REG_MIN_CLASS: min_class_reg <= pwdata[4:0];
                    scfl_pkg::REG_MAX_CLASS: max_class_reg <= pwdata[4:0];
                    scfl_pkg::REG_BUDGET:    budget_reg    <= pwdata;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            handle_reg <= block_handle;
            info_reg   <= info;
        end
        if (exec)
        begin
            status_reg    <= status_next;
            granted_reg   <= info_reg.granted_len;
            class_idx_reg <= info_reg.class_index;
            pop_flag_reg  <= pop;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            scfl_pkg::REG_MIN_CLASS: prdata = {27'd0, min_class_reg};
            scfl_pkg::REG_MAX_CLASS: prdata = {27'd0, max_class_reg};
            scfl_pkg::REG_BUDGET:    prdata = budget_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign handle_out   = pop_flag_reg ? ram_rdata_ext[31:0] : 32'd0;
    assign granted_len  = granted_reg;
    assign class_index  = class_idx_reg;
    assign pooled_bytes = held_reg;

    `SCFL_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted word did not start work")
    `SCFL_ASSERT_SAME(a_done_after_exec, done, $past(state_reg == S_EXEC),
        "result strobe without a preceding update cycle")
    `SCFL_ASSERT_SAME(a_count_bound, exec, cnt <= CNT_W'(LIST_DEPTH),
        "class count beyond list depth")
    `SCFL_ASSERT_SAME(a_stored_grows, done && status == scfl_pkg::ST_STORED,
        held_reg > $past(held_reg), "stored block did not raise pooled bytes")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Size-class free-list pool: self-checking testbench
// Drives allocate and return commands through the start/busy port and checks
// every result word against an in-bench model of the class lists and the
// pooled-byte count. Register settings change between phases over the
// configuration port, and each setting is read back.
// ----------------------------------------------------------------------------
module testbench;
    import scfl_pkg::*;

    localparam int CLASSES = NUM_CLASSES_DEF;
    localparam int DEPTH   = LIST_DEPTH_DEF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct {
        status_t     st;
        logic [31:0] handle;
        logic [31:0] len;
        logic [3:0]  cls;
        logic [32:0] pooled;
    } pool_word_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [31:0]         size_bytes;
    logic [31:0]         block_handle;
    logic                done;
    logic [2:0]          status;
    logic [31:0]         handle_out;
    logic [31:0]         granted_len;
    logic [3:0]          class_index;
    logic [32:0]         pooled_bytes;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // pool model
    logic [31:0]  free_store [CLASSES][DEPTH];
    int unsigned  head_ptr [CLASSES];
    int unsigned  tail_ptr [CLASSES];
    int unsigned  fill [CLASSES];
    logic [63:0]  held;
    logic [4:0]   min_cls;
    logic [4:0]   max_cls;
    logic [31:0]  budget;

    pool_word_t   pending_words [16];
    int           mismatches;
    int           words_sent;
    int           words_checked;
    int           config_phases;
    logic [7:0]   status_seen;
    bit           no_gaps;

    size_class_free_list_pool DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .size_bytes   (size_bytes),
        .block_handle (block_handle),
        .done         (done),
        .status       (status),
        .handle_out   (handle_out),
        .granted_len  (granted_len),
        .class_index  (class_index),
        .pooled_bytes (pooled_bytes),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("testbench: mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic pool_word_t pool_apply(input logic c, input logic [31:0] sz,
                                              input logic [31:0] h);
        pool_word_t  w;
        int          k;
        int          cls;
        bit          managed;
        logic [63:0] glen;
        w.st = ST_ZERO;
        w.handle = '0;
        w.len = '0;
        w.cls = '0;
        k = 0;
        cls = 0;
        managed = 1'b0;
        glen = '0;
        if (sz != 32'd0)
        begin
            while (k < 32 && (64'd1 << k) < {32'd0, sz})
                k++;
            glen = 64'd1 << k;
            w.len = glen[31:0];
            managed = k >= int'(min_cls) && k <= int'(max_cls)
                      && k - int'(min_cls) < CLASSES;
            if (managed)
            begin
                cls = k - int'(min_cls);
                w.cls = cls[3:0];
            end
        end
        if (c == CMD_ALLOC)
        begin
            if (sz == 32'd0)
                w.st = ST_ZERO;
            else if (!managed)
                w.st = ST_UNMANAGED;
            else if (fill[cls] == 0)
                w.st = ST_EMPTY;
            else
            begin
                w.handle = free_store[cls][head_ptr[cls]];
                head_ptr[cls] = (head_ptr[cls] + 1) % DEPTH;
                fill[cls]--;
                held = (held >= glen) ? held - glen : 64'd0;
                w.st = ST_POOLED;
            end
        end
        else
        begin
            if (sz == 32'd0 || (sz & (sz - 32'd1)) != 32'd0 || !managed)
                w.st = ST_DROP_UNMAN;
            else if (held >= {32'd0, budget})
                w.st = ST_DROP_BUDGET;
            else if (fill[cls] >= DEPTH)
                w.st = ST_DROP_FULL;
            else
            begin
                free_store[cls][tail_ptr[cls]] = h;
                tail_ptr[cls] = (tail_ptr[cls] + 1) % DEPTH;
                fill[cls]++;
                held = held + {32'd0, sz};
                w.st = ST_STORED;
            end
        end
        w.pooled = held[32:0];
        return w;
    endfunction

    function automatic logic [31:0] class_size(input int k);
        logic [63:0] span;
        logic [63:0] v;
        if (k == 0)
            return 32'd1;
        span = 64'd1 << (k - 1);
        v = span + 64'd1 + ({32'd0, $urandom} % span);
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(input reg_idx_t r);
        return ADDR_W'({r, 2'b00});
    endfunction

    task automatic send_word(input logic c, input logic [31:0] sz, input logic [31:0] h);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(99) < 11)
            gap = $urandom_range(1, 4);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        cmd = c;
        size_bytes = sz;
        block_handle = h;
        do
            @(posedge clk);
        while (busy);
        pending_words[words_sent % 16] = pool_apply(c, sz, h);
        words_sent++;
    endtask

    task automatic drain_words();
        @(negedge clk);
        start = 1'b0;
        while (words_sent != words_checked)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = reg_addr(r);
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (r)
            REG_MIN_CLASS: min_cls = v[4:0];
            REG_MAX_CLASS: max_cls = v[4:0];
            default:       budget = v;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t r);
        logic [31:0] want;
        case (r)
            REG_MIN_CLASS: want = {27'd0, min_cls};
            REG_MAX_CLASS: want = {27'd0, max_cls};
            default:       want = budget;
        endcase
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = reg_addr(r);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %s read %h, expected %h",
                                      r.name(), prdata, want));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_pool(input logic [4:0] lo, input logic [4:0] hi,
                            input logic [31:0] cap);
        drain_words();
        write_reg(REG_MIN_CLASS, {$urandom} & 32'hFFFF_FFE0 | {27'd0, lo});
        write_reg(REG_MAX_CLASS, {27'd0, hi});
        write_reg(REG_BUDGET, cap);
        check_reg(REG_MIN_CLASS);
        check_reg(REG_MAX_CLASS);
        check_reg(REG_BUDGET);
        config_phases++;
    endtask

    task automatic random_items(input int n, input int free_pct);
        int          lo;
        int          top;
        int          k;
        int          r;
        logic        c;
        logic [31:0] sz;
        lo = (min_cls > 0) ? int'(min_cls) - 1 : 0;
        if (max_cls >= min_cls)
            top = (int'(max_cls) - int'(min_cls) < CLASSES) ? int'(max_cls)
                                                             : int'(min_cls) + CLASSES - 1;
        else
            top = int'(min_cls);
        top = (top + 1 > 32) ? 32 : top + 1;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            c = ($urandom_range(99) < free_pct) ? CMD_FREE : CMD_ALLOC;
            if (r < 8)
                sz = $urandom;
            else if (r < 11)
                sz = 32'd0;
            else
            begin
                k = (r < 20) ? $urandom_range(0, 32) : $urandom_range(lo, top);
                if (c == CMD_FREE && k < 32 && $urandom_range(9) != 0)
                    sz = 32'd1 << k;
                else
                    sz = class_size(k);
            end
            send_word(c, sz, $urandom);
        end
    endtask

    task automatic test_register_reset();
        check_reg(REG_MIN_CLASS);
        check_reg(REG_MAX_CLASS);
        check_reg(REG_BUDGET);
    endtask

    task automatic test_directed();
        send_word(CMD_ALLOC, 32'd0, 32'h0);
        send_word(CMD_FREE, 32'd0, 32'h1111_1111);
        send_word(CMD_ALLOC, 32'd1, 32'h0);
        send_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_ALLOC, 32'h8000_0001, 32'h0);
        send_word(CMD_ALLOC, 32'h8000_0000, 32'h0);
        send_word(CMD_ALLOC, 32'd64, 32'h0);
        send_word(CMD_FREE, 32'd100, 32'h2222_2222);
        send_word(CMD_FREE, 32'd32, 32'h3333_3333);
        send_word(CMD_FREE, 32'd65536, 32'hFFFF_FFFF);
        send_word(CMD_FREE, 32'd131072, 32'h4444_4444);
        send_word(CMD_FREE, 32'h8000_0000, 32'h5555_5555);
        send_word(CMD_FREE, 32'd64, 32'h0);
        send_word(CMD_FREE, 32'd64, 32'hA5A5_5A5A);
        send_word(CMD_ALLOC, 32'd33, 32'h0);
        send_word(CMD_ALLOC, 32'd40000, 32'h0);
        send_word(CMD_ALLOC, 32'd64, 32'h0);
        send_word(CMD_ALLOC, 32'd64, 32'h0);
        send_word(CMD_FREE, 32'd128, 32'h1234_5678);
        send_word(CMD_ALLOC, 32'd65, 32'hFFFF_FFFF);
    endtask

    task automatic test_budget_drop();
        set_pool(5'd6, 5'd16, 32'd512);
        send_word(CMD_FREE, 32'd256, 32'hCAFE_0001);
        send_word(CMD_FREE, 32'd256, 32'hCAFE_0002);
        send_word(CMD_FREE, 32'd64, 32'hCAFE_0003);
        send_word(CMD_ALLOC, 32'd200, 32'h0);
        send_word(CMD_ALLOC, 32'd256, 32'h0);
        set_pool(5'd6, 5'd16, 32'd0);
        send_word(CMD_FREE, 32'd64, 32'hCAFE_0004);
        send_word(CMD_ALLOC, 32'd64, 32'h0);
    endtask

    task automatic test_list_full();
        set_pool(5'd3, 5'd3, 32'hFFFF_FFFF);
        repeat (DEPTH + 2) send_word(CMD_FREE, 32'd8, $urandom);
        repeat (DEPTH + 2) send_word(CMD_ALLOC, $urandom_range(5, 8), $urandom);
    endtask

    task automatic test_byte_underflow();
        set_pool(5'd0, 5'd15, 32'hFFFF_FFFF);
        repeat (3) send_word(CMD_FREE, 32'd1, $urandom);
        send_word(CMD_FREE, 32'd2, $urandom);
        set_pool(5'd10, 5'd25, 32'hFFFF_FFFF);
        send_word(CMD_ALLOC, 32'd1000, 32'h0);
        send_word(CMD_ALLOC, 32'd2048, 32'h0);
        send_word(CMD_ALLOC, 32'd1024, 32'h0);
        send_word(CMD_ALLOC, 32'd513, 32'h0);
    endtask

    task automatic test_random_mix();
        set_pool(5'd6, 5'd16, 32'h0010_0000);
        random_items(80, 55);
        no_gaps = 1'b1;
        set_pool(5'd0, 5'd31, 32'hFFFF_FFFF);
        random_items(80, 55);
        no_gaps = 1'b0;
        set_pool(5'd31, 5'd0, 32'd1000);
        random_items(30, 50);
        set_pool(5'd31, 5'd31, 32'hFFFF_FFFF);
        random_items(40, 55);
        set_pool(5'd0, 5'd0, 32'h40);
        random_items(40, 60);
        repeat (3)
        begin
            set_pool($urandom_range(0, 31), $urandom_range(0, 31),
                     ($urandom_range(1) != 0) ? $urandom : 32'd1 << $urandom_range(8, 31));
            random_items(50, 55);
        end
        set_pool(5'd16, 5'd31, 32'h8000_0000);
        random_items(50, 50);
        set_pool(5'd2, 5'd4, 32'h0000_0400);
        random_items(50, 60);
    endtask

    always @(posedge clk)
    begin : check_words
        pool_word_t want;
        if (rst_n && done)
        begin
            if (words_sent == words_checked)
                report_mismatch($sformatf("word with no command outstanding, status %0d",
                                          status));
            else
            begin
                want = pending_words[words_checked % 16];
                words_checked++;
                status_seen[want.st] = 1'b1;
                if (status !== want.st)
                    report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                              words_checked, status, want.st));
                if (handle_out !== want.handle)
                    report_mismatch($sformatf("word %0d handle_out %h, expected %h",
                                              words_checked, handle_out, want.handle));
                if (granted_len !== want.len)
                    report_mismatch($sformatf("word %0d granted_len %h, expected %h",
                                              words_checked, granted_len, want.len));
                if (class_index !== want.cls)
                    report_mismatch($sformatf("word %0d class_index %0d, expected %0d",
                                              words_checked, class_index, want.cls));
                if (pooled_bytes !== want.pooled)
                    report_mismatch($sformatf("word %0d pooled_bytes %h, expected %h",
                                              words_checked, pooled_bytes, want.pooled));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ALLOC;
        size_bytes = '0;
        block_handle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        config_phases = 0;
        status_seen = '0;
        no_gaps = 1'b0;
        min_cls = MIN_CLASS_RST;
        max_cls = MAX_CLASS_RST;
        budget = BUDGET_RST;
        held = '0;
        for (int i = 0; i < CLASSES; i++)
        begin
            head_ptr[i] = 0;
            tail_ptr[i] = 0;
            fill[i] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_directed();
        test_budget_drop();
        test_list_full();
        test_byte_underflow();
        test_random_mix();
        drain_words();

        $display("testbench: %0d commands sent, %0d words checked over %0d register settings",
                 words_sent, words_checked, config_phases);
        $display("testbench: status codes reached (bit per code) %b", status_seen);
        if (mismatches == 0 && words_sent == words_checked)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
